// ===== hdl/smo_violating_pair_and_rho_scan_macros.svh =====
// Assertion macros used by the violating-pair scan controller RTL
`ifndef SMO_VIOLATING_PAIR_AND_RHO_SCAN_MACROS_SVH
`define SMO_VIOLATING_PAIR_AND_RHO_SCAN_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SMOVP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SMOVP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/smovp_pkg.sv =====
// Types and constants for the violating-pair and rho scan
`timescale 1ns / 1ps
package smovp_pkg;
	localparam int GW    = 32;  // gradient width
	localparam int SUM_W = 42;  // free-variable sum width
	localparam int CNT_W = 11;  // free-variable count width
	localparam int IDX_W = 10;  // index output width
	localparam int EPS_W = 31;  // tolerance width

	localparam logic signed [GW-1:0] GMAX = {1'b0, {(GW-1){1'b1}}};
	localparam logic signed [GW-1:0] GMIN = {1'b1, {(GW-1){1'b0}}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration register indexes
	localparam logic REG_NU_MODE  = 1'b0;
	localparam logic REG_STOP_TOL = 1'b1;

	// bound status codes
	localparam logic [1:0] ST_LOWER = 2'd0;
	localparam logic [1:0] ST_UPPER = 2'd1;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_cls;
		logic store0;
		logic store1;
		logic finish;
	} smovp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_done;
	} smovp_sts_t;
endpackage

// ===== hdl/smovp_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned
`timescale 1ns / 1ps
module smovp_div
	import smovp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);
	localparam int CW = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [SUM_W-1:0] quo_q;

	logic [CNT_W:0]   trial;
	logic             qbit;
	logic [CNT_W:0]   diff;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[SUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out at the top, quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== hdl/smovp_dp.sv =====
// Datapath: running maxima, rho bounds, free sums and result formation
`timescale 1ns / 1ps
module smovp_dp
	import smovp_pkg::*;
#(
	parameter int MAX_VARS = 1024,
	parameter int POS_W    = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smovp_cmd_t              cmd,
	output smovp_sts_t              sts,
	input  logic                    nu_mode,
	input  logic [EPS_W-1:0]        stop_tolerance,
	input  logic                    label_positive,
	input  logic signed [GW-1:0]    gradient,
	input  logic [1:0]              bound_status,
	output logic                    converged,
	output logic [IDX_W-1:0]        first_index,
	output logic [IDX_W-1:0]        second_index,
	output logic signed [GW-1:0]    rho,
	output logic signed [GW-1:0]    class_mean
);
	// scan state
	logic [POS_W-1:0]           pos_q;
	logic signed [GW-1:0]       mv_q  [4];
	logic [POS_W-1:0]           mp_q  [4];
	logic [3:0]                 mf_q;
	logic signed [GW-1:0]       ul_q  [2];
	logic signed [GW-1:0]       ll_q  [2];
	logic signed [SUM_W-1:0]    sum_q [2];
	logic [CNT_W-1:0]           cnt_q [2];
	logic [SUM_W-1:0]           quo0_q;
	logic [SUM_W-1:0]           quo1_q;

	// saturate a 43-bit signed value to GW bits
	function automatic logic signed [GW-1:0] sat_w(input logic signed [SUM_W:0] v);
		logic signed [SUM_W:0] hi;
		logic signed [SUM_W:0] lo;
		hi = (SUM_W+1)'(GMAX);
		lo = (SUM_W+1)'(GMIN);
		if (v > hi)
			return GMAX;
		else if (v < lo)
			return GMIN;
		else
			return v[GW-1:0];
	endfunction

	// halve toward zero
	function automatic logic signed [GW:0] half_tz(input logic signed [GW:0] v);
		logic signed [GW:0] a;
		a = v + {{GW{1'b0}}, (v[GW] & v[0])};
		return a >>> 1;
	endfunction

	// item decode
	logic signed [GW-1:0]  ng;
	logic signed [GW-1:0]  yg;
	logic signed [GW-1:0]  lv;
	logic                  is_low;
	logic                  is_up;
	logic                  is_free;
	logic [1:0]            slot_ng;
	logic [1:0]            slot_g;
	logic                  cls;
	logic                  ul_upd;
	logic                  ll_upd;
	logic signed [SUM_W:0] sum_nx;
	logic signed [SUM_W-1:0] sum_sat;

	always_comb begin
		ng      = (gradient == GMIN) ? GMAX : -gradient;
		yg      = label_positive ? gradient : ng;
		is_low  = (bound_status == ST_LOWER);
		is_up   = (bound_status == ST_UPPER);
		is_free = !is_low && !is_up;
		if (nu_mode) begin
			slot_ng = label_positive ? 2'd0 : 2'd2;
			slot_g  = label_positive ? 2'd1 : 2'd3;
			cls     = !label_positive;
			lv      = gradient;
			ul_upd  = is_low;
			ll_upd  = is_up;
		end else begin
			slot_ng = label_positive ? 2'd0 : 2'd1;
			slot_g  = label_positive ? 2'd1 : 2'd0;
			cls     = 1'b0;
			lv      = yg;
			ul_upd  = (is_low && label_positive) || (is_up && !label_positive);
			ll_upd  = (is_low && !label_positive) || (is_up && label_positive);
		end
		sum_nx = {sum_q[cls][SUM_W-1], sum_q[cls]} + (SUM_W+1)'(lv);
		if (sum_nx[SUM_W] != sum_nx[SUM_W-1])
			sum_sat = sum_nx[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_nx[SUM_W-1:0];
	end

	// divider operands: magnitude of the chosen class sum and its count
	logic [SUM_W-1:0] div_mag;
	logic             div_done;
	logic [SUM_W-1:0] div_quo;

	always_comb begin
		div_mag = sum_q[cmd.div_cls][SUM_W-1] ? (~sum_q[cmd.div_cls] + 1'b1)
						      : sum_q[cmd.div_cls];
	end

	smovp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_mag),
		.divisor  (cnt_q[cmd.div_cls]),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sts.div_done = div_done;

	// class estimates and final results
	logic signed [GW-1:0]  est   [2];
	logic signed [SUM_W:0] qs    [2];
	logic signed [GW:0]    mid   [2];
	logic signed [GW:0]    r_df;
	logic signed [GW:0]    r_sm;
	logic signed [GW:0]    s01;
	logic signed [GW:0]    s23;
	logic signed [GW:0]    best;
	logic signed [GW:0]    eps_s;
	logic                  use01;
	logic                  conv_nx;
	logic [IDX_W-1:0]      pick  [4];

	always_comb begin
		qs[0] = sum_q[0][SUM_W-1] ? -$signed({1'b0, quo0_q}) : $signed({1'b0, quo0_q});
		qs[1] = sum_q[1][SUM_W-1] ? -$signed({1'b0, quo1_q}) : $signed({1'b0, quo1_q});
		for (int c = 0; c < 2; c++) begin
			mid[c] = half_tz({ul_q[c][GW-1], ul_q[c]} + {ll_q[c][GW-1], ll_q[c]});
			est[c] = (cnt_q[c] != '0) ? sat_w(qs[c]) : mid[c][GW-1:0];
		end
		r_df = half_tz({est[0][GW-1], est[0]} - {est[1][GW-1], est[1]});
		r_sm = half_tz({est[0][GW-1], est[0]} + {est[1][GW-1], est[1]});
		s01   = {mv_q[0][GW-1], mv_q[0]} + {mv_q[1][GW-1], mv_q[1]};
		s23   = {mv_q[2][GW-1], mv_q[2]} + {mv_q[3][GW-1], mv_q[3]};
		eps_s = {2'b00, stop_tolerance};
		use01 = !nu_mode || (s01 > s23);
		best  = use01 ? s01 : s23;
		conv_nx = (best < eps_s);
		for (int k = 0; k < 4; k++)
			pick[k] = mf_q[k] ? IDX_W'(mp_q[k]) : '0;
	end

	// scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			mf_q  <= '0;
			for (int k = 0; k < 4; k++) begin
				mv_q[k] <= GMIN;
				mp_q[k] <= '0;
			end
			for (int c = 0; c < 2; c++) begin
				ul_q[c]  <= GMAX;
				ll_q[c]  <= GMIN;
				sum_q[c] <= '0;
				cnt_q[c] <= '0;
			end
		end else if (cmd.finish) begin
			pos_q <= '0;
			mf_q  <= '0;
			for (int k = 0; k < 4; k++) begin
				mv_q[k] <= GMIN;
				mp_q[k] <= '0;
			end
			for (int c = 0; c < 2; c++) begin
				ul_q[c]  <= GMAX;
				ll_q[c]  <= GMIN;
				sum_q[c] <= '0;
				cnt_q[c] <= '0;
			end
		end else if (cmd.accept) begin
			pos_q <= (pos_q == POS_W'(MAX_VARS - 1)) ? '0 : pos_q + 1'b1;
			for (int k = 0; k < 4; k++) begin
				if (!is_up && slot_ng == 2'(k) && ng >= mv_q[k]) begin
					mv_q[k] <= ng;
					mp_q[k] <= pos_q;
					mf_q[k] <= 1'b1;
				end else if (!is_low && slot_g == 2'(k) && gradient >= mv_q[k]) begin
					mv_q[k] <= gradient;
					mp_q[k] <= pos_q;
					mf_q[k] <= 1'b1;
				end
			end
			if (ul_upd && lv < ul_q[cls])
				ul_q[cls] <= lv;
			if (ll_upd && lv > ll_q[cls])
				ll_q[cls] <= lv;
			if (is_free) begin
				sum_q[cls] <= sum_sat;
				if (cnt_q[cls] != CNT_MAX)
					cnt_q[cls] <= cnt_q[cls] + 1'b1;
			end
		end
	end

	// quotient capture and result register
	always_ff @(posedge clk) begin
		if (cmd.store0)
			quo0_q <= div_quo;
		if (cmd.store1)
			quo1_q <= div_quo;
		if (cmd.finish) begin
			converged    <= conv_nx;
			first_index  <= conv_nx ? '0 : (use01 ? pick[0] : pick[2]);
			second_index <= conv_nx ? '0 : (use01 ? pick[1] : pick[3]);
			if (nu_mode) begin
				rho        <= sat_w((SUM_W+1)'(r_df));
				class_mean <= sat_w((SUM_W+1)'(r_sm));
			end else begin
				rho        <= est[0];
				class_mean <= '0;
			end
		end
	end
endmodule

// ===== hdl/smovp_ctrl.sv =====
// Controller: scan, two divisions, result formation and hand-off
`timescale 1ns / 1ps
`include "smo_violating_pair_and_rho_scan_macros.svh"
module smovp_ctrl
	import smovp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       last,
	input  logic       out_ready,
	input  smovp_sts_t sts,
	output smovp_cmd_t cmd,
	output logic       in_ready,
	output logic       out_valid
);
	localparam logic [2:0] S_SCAN  = 3'd0;
	localparam logic [2:0] S_DIV0  = 3'd1;
	localparam logic [2:0] S_WAIT0 = 3'd2;
	localparam logic [2:0] S_DIV1  = 3'd3;
	localparam logic [2:0] S_WAIT1 = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_ready  = (state_q == S_SCAN);
	assign out_valid = (state_q == S_OUT);

	// commands
	always_comb begin
		cmd.accept    = in_valid && in_ready;
		cmd.div_start = (state_q == S_DIV0) || (state_q == S_DIV1);
		cmd.div_cls   = (state_q == S_DIV1);
		cmd.store0    = (state_q == S_WAIT0) && sts.div_done;
		cmd.store1    = (state_q == S_WAIT1) && sts.div_done;
		cmd.finish    = (state_q == S_FIN);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_SCAN:  if (in_valid && last) state_nx = S_DIV0;
			S_DIV0:  state_nx = S_WAIT0;
			S_WAIT0: if (sts.div_done) state_nx = S_DIV1;
			S_DIV1:  state_nx = S_WAIT1;
			S_WAIT1: if (sts.div_done) state_nx = S_FIN;
			S_FIN:   state_nx = S_OUT;
			S_OUT:   if (out_ready) state_nx = S_SCAN;
			default: state_nx = S_SCAN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_SCAN;
		else
			state_q <= state_nx;
	end

	`SMOVP_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken while result pending")
	`SMOVP_ASSERT_NXT(a_last_blocks, cmd.accept && last, !in_ready, "scan continued past last")
	`SMOVP_ASSERT_IMP(a_done_waits, sts.div_done, (state_q == S_WAIT0) || (state_q == S_WAIT1), "divider done outside wait")
	`SMOVP_ASSERT_NXT(a_fin_out, cmd.finish, out_valid, "result not presented after finish")
endmodule

// ===== hdl/smo_violating_pair_and_rho_scan.sv =====
// Top level of the SMO violating-pair selection and rho scan
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   in       | in_valid / in_ready    | label_positive, gradient, bound_status, last
//   out      | out_valid / out_ready  | converged, first_index, second_index, rho,
//            |                        | class_mean
//   config   | wr_en (no wait)        | wr_index, wr_data
//
// Scan items are taken one per cycle while in_ready is high. After the last item two serial
// divisions (free sum by free count, one per class), each a start, 42 quotient bits and
// done, then a result formation step run in turn before out_valid rises. in_ready stays
// low from the last request until the result is taken.
// Reset clears scan state and sets nu_mode to 0 and stop_tolerance to 65.
`timescale 1ns / 1ps
module smo_violating_pair_and_rho_scan
	import smovp_pkg::*;
#(
	parameter int MAX_VARS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic                 wr_index,
	input  logic [EPS_W-1:0]     wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 label_positive,
	input  logic signed [GW-1:0] gradient,
	input  logic [1:0]           bound_status,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 converged,
	output logic [IDX_W-1:0]     first_index,
	output logic [IDX_W-1:0]     second_index,
	output logic signed [GW-1:0] rho,
	output logic signed [GW-1:0] class_mean
);
	localparam int POS_W = (MAX_VARS > 2) ? $clog2(MAX_VARS) : 1;

	logic             nu_mode_q;
	logic [EPS_W-1:0] stop_tol_q;
	smovp_cmd_t       cmd;
	smovp_sts_t       sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nu_mode_q  <= 1'b0;
			stop_tol_q <= EPS_W'(65);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_NU_MODE:  nu_mode_q  <= wr_data[0];
				REG_STOP_TOL: stop_tol_q <= wr_data;
				default: ;
			endcase
		end
	end

	smovp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	smovp_dp #(
		.MAX_VARS (MAX_VARS),
		.POS_W    (POS_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.nu_mode        (nu_mode_q),
		.stop_tolerance (stop_tol_q),
		.label_positive (label_positive),
		.gradient       (gradient),
		.bound_status   (bound_status),
		.converged      (converged),
		.first_index    (first_index),
		.second_index   (second_index),
		.rho            (rho),
		.class_mean     (class_mean)
	);
endmodule

// ===== dv/smo_violating_pair_and_rho_scan_test.sv =====
// Self-checking testbench for the SMO violating-pair selection and rho scan
`timescale 1ns / 1ps
module smo_violating_pair_and_rho_scan_test
	import smovp_pkg::*;
();

	localparam int IDLE_MAX = 6;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint SCORE_MAX = (64'sd1 <<< 41) - 1;
	localparam longint SCORE_MIN = -SCORE_MAX - 1;
	localparam logic [1:0] ST_FREE = 2'd2;
	localparam logic [1:0] ST_ODD = 2'd3;

	typedef struct packed {
		logic conv;
		logic [IDX_W-1:0] fi;
		logic [IDX_W-1:0] si;
		logic signed [GW-1:0] rho;
		logic signed [GW-1:0] mean;
	} pair_result_t;

	logic clk, arst_n;
	logic wr_en, wr_index;
	logic [EPS_W-1:0] wr_data;
	logic in_valid, in_ready;
	logic label_positive;
	logic signed [GW-1:0] gradient;
	logic [1:0] bound_status;
	logic last;
	logic out_valid, out_ready;
	logic converged;
	logic [IDX_W-1:0] first_index, second_index;
	logic signed [GW-1:0] rho, class_mean;

	smo_violating_pair_and_rho_scan u_top (.*);

	// predictor copy of configuration and scan state
	logic nu_on;
	logic [EPS_W-1:0] tol;
	int unsigned pos;
	longint viol_max[4];
	int unsigned viol_pos[4];
	bit viol_seen[4];
	longint up_lim[2], lo_lim[2], fsum[2];
	int unsigned fcnt[2];

	pair_result_t pending_pairs[$];
	int errors = 0;
	int idle_cycles = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void clear_scan();
		pos = 0;
		for (int k = 0; k < 4; k++) begin
			viol_max[k] = GMIN;
			viol_pos[k] = 0;
			viol_seen[k] = 0;
		end
		for (int k = 0; k < 2; k++) begin
			up_lim[k] = GMAX;
			lo_lim[k] = GMIN;
			fsum[k] = 0;
			fcnt[k] = 0;
		end
	endfunction

	function automatic void note_violation(int k, longint v);
		if (v >= viol_max[k]) begin
			viol_max[k] = v;
			viol_pos[k] = pos;
			viol_seen[k] = 1;
		end
	endfunction

	function automatic void add_free(int c, longint v);
		longint s;
		s = fsum[c] + v;
		if (s > SCORE_MAX) s = SCORE_MAX;
		if (s < SCORE_MIN) s = SCORE_MIN;
		fsum[c] = s;
		if (fcnt[c] < CNT_MAX) fcnt[c]++;
	endfunction

	function automatic longint class_estimate(int c);
		if (fcnt[c] > 0) return fsum[c] / longint'(fcnt[c]);
		return (up_lim[c] + lo_lim[c]) / 2;
	endfunction

	function automatic logic [IDX_W-1:0] chosen(int k);
		return viol_seen[k] ? IDX_W'(viol_pos[k]) : '0;
	endfunction

	// fold one variable into the scan; queue the pair result on last
	function automatic void predict_scan(logic lp, logic signed [GW-1:0] gr, logic [1:0] st,
		logic lst);
		longint g, ng, yg, s12, s34, best, r1, r2;
		bit lower, upper;
		pair_result_t r;
		g = gr;
		ng = (gr == GMIN) ? longint'(GMAX) : -g;
		lower = (st == ST_LOWER);
		upper = (st == ST_UPPER);
		if (!nu_on) begin
			yg = lp ? g : ng;
			if (!upper) note_violation(lp ? 0 : 1, ng);
			if (!lower) note_violation(lp ? 1 : 0, g);
			if (lower) begin
				if (lp) begin
					if (yg < up_lim[0]) up_lim[0] = yg;
				end else if (yg > lo_lim[0]) lo_lim[0] = yg;
			end else if (upper) begin
				if (lp) begin
					if (yg > lo_lim[0]) lo_lim[0] = yg;
				end else if (yg < up_lim[0]) up_lim[0] = yg;
			end else add_free(0, yg);
		end else begin
			int c;
			c = lp ? 0 : 1;
			if (!upper) note_violation(2 * c, ng);
			if (!lower) note_violation(2 * c + 1, g);
			if (lower) begin
				if (g < up_lim[c]) up_lim[c] = g;
			end else if (upper) begin
				if (g > lo_lim[c]) lo_lim[c] = g;
			end else add_free(c, g);
		end
		if (!lst) begin
			pos = (pos + 1) % 1024;
			return;
		end
		r = '0;
		if (!nu_on) begin
			s12 = viol_max[0] + viol_max[1];
			r.conv = s12 < longint'(tol);
			if (!r.conv) begin
				r.fi = chosen(0);
				r.si = chosen(1);
			end
			r.rho = GW'(clip32(class_estimate(0)));
		end else begin
			s12 = viol_max[0] + viol_max[1];
			s34 = viol_max[2] + viol_max[3];
			best = (s12 > s34) ? s12 : s34;
			r.conv = best < longint'(tol);
			if (!r.conv) begin
				r.fi = (s12 > s34) ? chosen(0) : chosen(2);
				r.si = (s12 > s34) ? chosen(1) : chosen(3);
			end
			r1 = clip32(class_estimate(0));
			r2 = clip32(class_estimate(1));
			r.rho = GW'(clip32((r1 - r2) / 2));
			r.mean = GW'(clip32((r1 + r2) / 2));
		end
		pending_pairs.push_back(r);
		clear_scan();
	endfunction

	// send one variable with a random lead-in gap; valid drops only ahead of a gap
	task automatic send_var(logic lp, logic signed [GW-1:0] gr, logic [1:0] st, logic lst);
		int gap;
		gap = $urandom_range(0, IDLE_MAX);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		label_positive <= lp;
		gradient <= gr;
		bound_status <= st;
		last <= lst;
		do @(posedge clk); while (!in_ready);
		predict_scan(lp, gr, st, lst);
	endtask

	// wait for the pair queue to drain, then let the block settle
	task automatic wait_idle();
		in_valid <= 0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [EPS_W-1:0] val);
		wait_idle();
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
		if (idx == REG_NU_MODE) nu_on = val[0];
		else tol = val;
	endtask

	function automatic logic signed [GW-1:0] rand_grad();
		case ($urandom_range(0, 5))
			0: return GMIN;
			1: return GMAX;
			2: return GW'($urandom_range(0, 20)) - 10;
			3: return GW'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	// random scans, mostly of small length, with mostly valid statuses
	task automatic run_random_scans(int n_vars);
		int sent;
		int len;
		logic [1:0] st;
		sent = 0;
		while (sent < n_vars) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				st = ($urandom_range(0, 15) == 0) ? ST_ODD : 2'($urandom_range(0, 2));
				send_var(1'($urandom_range(0, 1)), rand_grad(), st, i == len - 1);
				sent++;
			end
		end
	endtask

	task automatic test_directed_standard();
		send_var(1, GMIN, ST_LOWER, 0);
		send_var(0, GMAX, ST_UPPER, 0);
		send_var(1, GMAX, ST_FREE, 0);
		send_var(0, GMIN, ST_ODD, 1);
		// ties go to the later position
		send_var(1, 32'sh10000, ST_FREE, 0);
		send_var(1, 32'sh10000, ST_FREE, 1);
		// no free variables: rho from bounds
		send_var(1, 32'sh20000, ST_LOWER, 0);
		send_var(0, -32'sh30000, ST_UPPER, 1);
		send_var(1, 0, ST_FREE, 1);
	endtask

	task automatic test_directed_nu();
		send_var(1, GMIN, ST_LOWER, 0);
		send_var(0, GMAX, ST_UPPER, 0);
		send_var(1, 32'sh50000, ST_FREE, 0);
		send_var(0, -32'sh50000, ST_FREE, 1);
		// equal class pair sums pick the -1 class
		send_var(1, 32'sh10000, ST_FREE, 0);
		send_var(0, 32'sh10000, ST_FREE, 1);
		send_var(1, GMAX, ST_UPPER, 0);
		send_var(0, GMIN, ST_LOWER, 1);
	endtask

	// result checker with random stalls
	always @(posedge clk or negedge arst_n) begin
		pair_result_t want;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_pairs.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					want = pending_pairs.pop_front();
					if (converged !== want.conv) begin
						$error("converged exp %0d got %0d", want.conv, converged); errors++;
					end
					if (first_index !== want.fi) begin
						$error("first_index exp %0d got %0d", want.fi, first_index); errors++;
					end
					if (second_index !== want.si) begin
						$error("second_index exp %0d got %0d", want.si, second_index); errors++;
					end
					if (rho !== want.rho) begin
						$error("rho exp %0d got %0d", want.rho, rho); errors++;
					end
					if (class_mean !== want.mean) begin
						$error("class_mean exp %0d got %0d", want.mean, class_mean); errors++;
					end
				end
			end
			out_ready <= ($urandom_range(0, IDLE_MAX) == 0) || ($urandom_range(0, 2) == 0);
		end
	end

	// watchdog on cycles without any request
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("smo_violating_pair_and_rho_scan_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		wr_en = 0;
		wr_index = 0;
		wr_data = 0;
		in_valid = 0;
		label_positive = 0;
		gradient = 0;
		bound_status = 0;
		last = 0;
		nu_on = 0;
		tol = 65;
		clear_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed_standard();
		write_reg(REG_NU_MODE, 1);
		test_directed_nu();
		write_reg(REG_STOP_TOL, '1);
		run_random_scans(100);
		write_reg(REG_STOP_TOL, 0);
		run_random_scans(100);
		write_reg(REG_NU_MODE, 0);
		run_random_scans(100);
		write_reg(REG_STOP_TOL, 31'h8_0000);
		run_random_scans(140);
		write_reg(REG_NU_MODE, 1);
		run_random_scans(140);
		wait_idle();
		if (errors == 0) $display("smo_violating_pair_and_rho_scan_test: clean");
		else $display("smo_violating_pair_and_rho_scan_test: errors");
		$finish;
	end
endmodule
